FILE: rtl/bqlpf_pkg.sv
// Shared types and constants for the biquad lowpass filter.
package bqlpf_pkg;

  // Width of both delay accumulators.
  localparam int DELAY_BITS = 40;

  // Configuration register index width and register map.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0 = 2'd0,
    REG_COEF_A1 = 2'd1,
    REG_COEF_A2 = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_ACC,
    ST_QUANT,
    ST_MUL_Y,
    ST_SUM,
    ST_UPDATE
  } state_t;

endpackage

FILE: rtl/biquad_lowpass_filter_top.sv
// A sample taken in ST_IDLE runs through ST_MUL_X, ST_ACC, ST_QUANT, ST_MUL_Y, ST_SUM and
// ST_UPDATE, which waits while an unread result is held; only then is the next one taken.
// The products come from the bit-serial shift-add multiplier, which takes one multiplier
// bit per cycle for b0*x and then for a1*y and a2*y side by side.
// A finished sample waits in the output register while the next one is taken.
// Reset (synchronous, rst_n low) clears coefficients, both delays and out_valid.
module biquad_lowpass_filter_top #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_in,
  input  logic                                   in_first_of_buffer,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          out_sample_out,
  output logic                                   out_clipped,
  input  logic                                   cfg_we,
  input  logic [bqlpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_FRAC_BITS+2:0]              cfg_data
);
  import bqlpf_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int WIDE_W = (PROD_W > DELAY_BITS) ? PROD_W : DELAY_BITS;
  localparam int ACC_W  = WIDE_W + 1;
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;
  localparam int SUM_W  = ((PROD_W + 2 > DELAY_BITS) ? PROD_W + 2 : DELAY_BITS) + 1;
  localparam int CNT_W  = $clog2(SAMPLE_BITS);

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0]      coef_b0_r, coef_a1_r, coef_a2_r;
  logic signed [DELAY_BITS-1:0]  d1_r, d2_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clip_r;

  logic [SAMPLE_BITS-1:0]        mplr_r;
  logic [CNT_W-1:0]              cnt_r;
  logic signed [PROD_W-1:0]      bx_r, p1_r, p2_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [SUM_W-1:0]       s_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          clip_r;

  logic                          in_fire, out_free, last_bit, neg_bit;
  logic signed [PROD_W-1:0]      b0_ext, a1_ext, a2_ext;
  logic signed [PROD_W-1:0]      add_b0, add_a1, add_a2;
  logic signed [ACC_W-1:0]       biased;
  logic signed [Q_W-1:0]         quot;
  logic [Q_W-SAMPLE_BITS:0]      quot_top;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_clip;
  logic signed [SUM_W-1:0]       t1, t2;

  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-DELAY_BITS:0] top;
    top = v[SUM_W-1:DELAY_BITS-1];
    if (&top || ~|top) begin
      return v[DELAY_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  endfunction

  assign in_ready       = (state_r == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

  assign last_bit = (cnt_r == CNT_W'(SAMPLE_BITS - 1));
  // The multiplier MSB carries negative weight in two's complement.
  assign neg_bit  = (cnt_r == '0);

  assign b0_ext = {{(PROD_W-COEF_W){coef_b0_r[COEF_W-1]}}, coef_b0_r};
  assign a1_ext = {{(PROD_W-COEF_W){coef_a1_r[COEF_W-1]}}, coef_a1_r};
  assign a2_ext = {{(PROD_W-COEF_W){coef_a2_r[COEF_W-1]}}, coef_a2_r};

  assign add_b0 = mplr_r[SAMPLE_BITS-1] ? b0_ext : '0;
  assign add_a1 = mplr_r[SAMPLE_BITS-1] ? a1_ext : '0;
  assign add_a2 = mplr_r[SAMPLE_BITS-1] ? a2_ext : '0;

  // Truncate toward zero: bias negative values before the arithmetic shift.
  always_comb begin
    biased   = acc_r + (acc_r[ACC_W-1] ? ACC_W'((1 << COEF_FRAC_BITS) - 1) : ACC_W'(0));
    quot     = biased[ACC_W-1:COEF_FRAC_BITS];
    quot_top = quot[Q_W-1:SAMPLE_BITS-1];
    if (&quot_top || ~|quot_top) begin
      y_sat  = quot[SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end else if (quot[Q_W-1]) begin
      y_sat  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      y_clip = 1'b1;
    end else begin
      y_sat  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      y_clip = 1'b1;
    end
  end

  assign t1 = s_r - {{(SUM_W-PROD_W){p1_r[PROD_W-1]}}, p1_r};
  assign t2 = {{(SUM_W-PROD_W){bx_r[PROD_W-1]}}, bx_r}
            - {{(SUM_W-PROD_W){p2_r[PROD_W-1]}}, p2_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_MUL_X;
      ST_MUL_X:  if (last_bit) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_QUANT;
      ST_QUANT:  state_nxt = ST_MUL_Y;
      ST_MUL_Y:  if (last_bit) state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      coef_b0_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_B0: coef_b0_r <= cfg_data;
          REG_COEF_A1: coef_a1_r <= cfg_data;
          REG_COEF_A2: coef_a2_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_first_of_buffer) begin
        d1_r <= '0;
        d2_r <= '0;
      end
      if (state_r == ST_UPDATE && out_free) begin
        d1_r        <= sat_delay(t1);
        d2_r        <= sat_delay(t2);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        mplr_r <= in_sample_in;
        cnt_r  <= '0;
        bx_r   <= '0;
      end
      ST_MUL_X: begin
        bx_r   <= neg_bit ? (bx_r <<< 1) - add_b0 : (bx_r <<< 1) + add_b0;
        mplr_r <= mplr_r << 1;
        cnt_r  <= cnt_r + 1'b1;
      end
      ST_ACC: begin
        acc_r <= {{(ACC_W-PROD_W){bx_r[PROD_W-1]}}, bx_r}
               + {{(ACC_W-DELAY_BITS){d1_r[DELAY_BITS-1]}}, d1_r};
      end
      ST_QUANT: begin
        y_r    <= y_sat;
        clip_r <= y_clip;
        mplr_r <= y_sat;
        cnt_r  <= '0;
        p1_r   <= '0;
        p2_r   <= '0;
      end
      ST_MUL_Y: begin
        p1_r   <= neg_bit ? (p1_r <<< 1) - add_a1 : (p1_r <<< 1) + add_a1;
        p2_r   <= neg_bit ? (p2_r <<< 1) - add_a2 : (p2_r <<< 1) + add_a2;
        mplr_r <= mplr_r << 1;
        cnt_r  <= cnt_r + 1'b1;
      end
      ST_SUM: begin
        s_r <= {{(SUM_W-DELAY_BITS){d2_r[DELAY_BITS-1]}}, d2_r}
             + ({{(SUM_W-PROD_W){bx_r[PROD_W-1]}}, bx_r} <<< 1);
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_sample_r <= y_r;
          out_clip_r   <= clip_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/bqlpf_checker.sv
// Port-level checks for the biquad lowpass filter, bound to the top level.
module bqlpf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_clipped
);

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_clipped))
    else $error("result changed while stalled");

  // A clipped sample sits at one of the rails.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_sample_out == S_MAX || out_sample_out == S_MIN)
    else $error("clipped sample not at a rail");

  // Busy right after taking a sample.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A new result appears only at the end of the sequence, never while idle.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared from idle");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind biquad_lowpass_filter_top bqlpf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bqlpf_checker (.*);

FILE: tb/biquad_lowpass_filter_top_test.sv
// Self-checking testbench for the biquad lowpass filter: directed table, then random phases.
module biquad_lowpass_filter_top_test;
  import bqlpf_pkg::*;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 3;
  localparam int LATENCY        = 2 * SAMPLE_BITS + 4;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t y;
    logic    clip;
  } filt_result_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    int                   data;
    sample_t              x;
    logic                 first;
    bit                   typed;
    sample_t              exp_y;
    logic                 exp_clip;
  } step_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  sample_t                    in_sample_in = '0;
  logic                       in_first_of_buffer = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  sample_t                    out_sample_out;
  logic                       out_clipped;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_BITS-1:0]       cfg_data = '0;

  // Filter state mirrored by the predictor
  logic signed [COEF_BITS-1:0] coef_b0 = '0;
  logic signed [COEF_BITS-1:0] coef_a1 = '0;
  logic signed [COEF_BITS-1:0] coef_a2 = '0;
  longint                      delay_one = 0;
  longint                      delay_two = 0;

  filt_result_t pending_outputs [$];
  step_row_t    rows [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           buf_left = 0;
  int           hold_req = 0;
  int           hold_left = 0;
  bit           quiet = 1'b0;

  biquad_lowpass_filter_top #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_first_of_buffer(in_first_of_buffer),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_clipped       (out_clipped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clamp(longint v, int bits, output bit hit);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      hit = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic filt_result_t filter_sample(sample_t x, logic first);
    filt_result_t r;
    longint       bx;
    longint       acc;
    longint       y;
    bit           hit;
    bit           unused;
    if (first) begin
      delay_one = 0;
      delay_two = 0;
    end
    bx  = longint'(coef_b0) * longint'(x);
    acc = bx + delay_one;
    y   = clamp(acc / (longint'(1) <<< COEF_FRAC_BITS), SAMPLE_BITS, hit);
    delay_one = clamp(2 * bx - longint'(coef_a1) * y + delay_two, DELAY_BITS, unused);
    delay_two = clamp(bx - longint'(coef_a2) * y, DELAY_BITS, unused);
    r.y    = sample_t'(y);
    r.clip = hit;
    return r;
  endfunction

  // Output checker
  always @(posedge clk) begin
    filt_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected transaction, sample_out %0d clipped %0b", $time,
                 out_sample_out, out_clipped);
        mismatches++;
      end else begin
        e = pending_outputs.pop_front();
        if (out_sample_out !== e.y) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, e.y, out_sample_out);
          mismatches++;
        end
        if (out_clipped !== e.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, e.clip, out_clipped);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random backpressure, long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 32);
    end
  end

  task automatic send_sample(sample_t x, logic first, bit typed, sample_t ey, logic ec);
    filt_result_t r;
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample_in       <= x;
    in_first_of_buffer <= first;
    do @(posedge clk); while (!in_ready);
    r = filter_sample(x, first);
    if (typed) begin
      r.y    = ey;
      r.clip = ec;
    end
    pending_outputs.push_back(r);
  endtask

  // Lower valid and wait until every expected transaction has come back
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[COEF_BITS-1:0];
    @(posedge clk);
    case (idx)
      REG_COEF_B0: coef_b0 = value[COEF_BITS-1:0];
      REG_COEF_A1: coef_a1 = value[COEF_BITS-1:0];
      REG_COEF_A2: coef_a2 = value[COEF_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end
    if (pick < 50) return sample_t'(int'($urandom_range(4000)) - 2000);
    return sample_t'($urandom());
  endfunction

  // Mostly buffers of random length, with some stray start marks mixed in
  function automatic logic next_first();
    logic f;
    if ($urandom_range(9) == 0) return 1'($urandom_range(1));
    f = (buf_left == 0);
    if (f) buf_left = $urandom_range(64, 1);
    buf_left--;
    return f;
  endfunction

  task automatic run_phase(int count, int b0, int a1, int a2, bit stray_write, int hold_at);
    drain_outputs();
    if (stray_write) write_reg(REG_UNMAPPED, int'($urandom()));
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    cfg_we   <= 1'b0;
    buf_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = HOLD_CYCLES;
      send_sample(random_sample(), next_first(), 1'b0, '0, 1'b0);
    end
  endtask

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int value);
    step_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = value;
    return r;
  endfunction

  function automatic step_row_t smp_row(sample_t x, logic first, bit typed = 1'b0,
                                        sample_t ey = '0, logic ec = 1'b0);
    step_row_t r;
    r = '{default: '0};
    r.x        = x;
    r.first    = first;
    r.typed    = typed;
    r.exp_y    = ey;
    r.exp_clip = ec;
    return r;
  endfunction

  initial begin
    // Coefficients are zero after reset, so the output is zero
    rows.push_back(smp_row(16'sh7FFF, 1'b1, 1'b1, 16'sd0, 1'b0));
    rows.push_back(smp_row(16'sh8000, 1'b0, 1'b1, 16'sd0, 1'b0));
    rows.push_back(smp_row(16'sh0000, 1'b0, 1'b1, 16'sd0, 1'b0));
    // Largest b0 with no feedback clips both ways
    rows.push_back(cfg_row(REG_COEF_B0, 131071));
    rows.push_back(smp_row(16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b1));
    rows.push_back(smp_row(16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b1));
    // Negative fraction truncates toward zero
    rows.push_back(cfg_row(REG_COEF_B0, 1));
    rows.push_back(smp_row(-16'sd1, 1'b1, 1'b1, 16'sd0, 1'b0));
    rows.push_back(smp_row(16'sh7FFF, 1'b0));
    rows.push_back(cfg_row(REG_COEF_B0, -131072));
    rows.push_back(smp_row(16'sh8000, 1'b1, 1'b1, 16'sh7FFF, 1'b1));
    rows.push_back(smp_row(16'sd1, 1'b1, 1'b1, -16'sd4, 1'b0));
    rows.push_back(cfg_row(REG_COEF_A1, -131072));
    rows.push_back(cfg_row(REG_COEF_A2, 131071));
    rows.push_back(smp_row(16'sh7FFF, 1'b0));
    rows.push_back(smp_row(16'sh8000, 1'b0));
    rows.push_back(smp_row(16'sd12345, 1'b0));
    rows.push_back(smp_row(-16'sd1, 1'b1));
    // Write to an unmapped index must not disturb the coefficients
    rows.push_back(cfg_row(REG_UNMAPPED, -1));
    rows.push_back(smp_row(16'sd777, 1'b0));
    rows.push_back(cfg_row(REG_COEF_B0, 5079));
    rows.push_back(cfg_row(REG_COEF_A1, -20322));
    rows.push_back(cfg_row(REG_COEF_A2, 7877));
    rows.push_back(smp_row(16'sh7FFF, 1'b1));
    rows.push_back(smp_row(16'sh0000, 1'b0));
    rows.push_back(smp_row(16'sh8000, 1'b0));
    rows.push_back(smp_row(16'sd1000, 1'b0));
    rows.push_back(smp_row(-16'sd1000, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        drain_outputs();
        write_reg(rows[i].idx, rows[i].data);
        cfg_we <= 1'b0;
      end else begin
        send_sample(rows[i].x, rows[i].first, rows[i].typed, rows[i].exp_y,
                    rows[i].exp_clip);
      end
    end

    run_phase(250, 128, -59484, 27230, 1'b0, -1);
    quiet = 1'b1;
    run_phase(250, 5079, -20322, 7877, 1'b1, -1);
    quiet = 1'b0;
    run_phase(250, 131071, 131071, -131072, 1'b0, 10);
    run_phase(250, -131072, -131072, 131071, 1'b1, -1);
    run_phase(250, int'($urandom_range(262143)), int'($urandom_range(262143)),
              int'($urandom_range(262143)), 1'b0, -1);
    run_phase(250, 16384, -32768, 16384, 1'b0, -1);
    run_phase(250, 3, 65536, 32767, 1'b1, -1);
    run_phase(250, int'($urandom_range(262143)), int'($urandom_range(262143)),
              int'($urandom_range(262143)), 1'b1, -1);

    drain_outputs();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
